### rtl/slsc_pkg.sv
// Shared types, codes and constants of the solenoid lock safety controller.
`timescale 1ns / 1ps

package slsc_pkg;

  // Event kinds carried in the input tuser field.
  localparam logic [3:0] KIND_TICK        = 4'd0;
  localparam logic [3:0] KIND_INIT        = 4'd1;
  localparam logic [3:0] KIND_UNLOCK      = 4'd2;
  localparam logic [3:0] KIND_LOCK        = 4'd3;
  localparam logic [3:0] KIND_UNJAM       = 4'd4;
  localparam logic [3:0] KIND_CLR_TAMPER  = 4'd5;
  localparam logic [3:0] KIND_SUPPRESS    = 4'd6;
  localparam logic [3:0] KIND_ARM         = 4'd7;
  localparam logic [3:0] KIND_RESET_UNJAM = 4'd8;

  // Result status codes.
  localparam logic [2:0] STATUS_OK          = 3'd0;
  localparam logic [2:0] STATUS_OVERHEATED  = 3'd1;
  localparam logic [2:0] STATUS_STUCK_OPEN  = 3'd2;
  localparam logic [2:0] STATUS_UNJAM_COOL  = 3'd3;
  localparam logic [2:0] STATUS_UNJAM_LIMIT = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] REG_DEBOUNCE      = 3'd0;
  localparam logic [2:0] REG_OPEN_CONFIRM  = 3'd1;
  localparam logic [2:0] REG_COOLDOWN      = 3'd2;
  localparam logic [2:0] REG_BOOT_GRACE    = 3'd3;
  localparam logic [2:0] REG_MAX_ACTIVE    = 3'd4;
  localparam logic [2:0] REG_TEMP_LIMIT    = 3'd5;
  localparam logic [2:0] REG_HEAT_PER_PULSE = 3'd6;
  localparam logic [2:0] REG_COOL_PER_MS   = 3'd7;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  // Configuration reset values.
  localparam logic [15:0] DEBOUNCE_RST      = 16'd50;
  localparam logic [19:0] OPEN_CONFIRM_RST  = 20'd1000;
  localparam logic [19:0] COOLDOWN_RST      = 20'd30000;
  localparam logic [19:0] BOOT_GRACE_RST    = 20'd5000;
  localparam logic [19:0] MAX_ACTIVE_RST    = 20'd10000;
  localparam logic [31:0] TEMP_LIMIT_RST    = 32'd4587520;
  localparam logic [23:0] HEAT_PER_PULSE_RST = 24'd327680;
  localparam logic [15:0] COOL_PER_MS_RST   = 16'd655;

  // Coil temperature floor, 25 C in 1/65536 C.
  localparam logic [31:0] TEMP_FLOOR = 32'd1638400;

  // Unjam pulse policy.
  localparam logic [3:0]  UNJAM_PULSES_MAX    = 4'd3;
  localparam logic [31:0] UNJAM_WIDTH_MS      = 32'd300;
  localparam logic [31:0] UNJAM_GAP_MS        = 32'd2000;
  localparam logic [31:0] UNJAM_IDLE_RESET_MS = 32'd60000;

  // One input event.
  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] now_ms;
    logic        reed_sample;
    logic        ignore_reed;
  } item_t;

  // One result.
  typedef struct packed {
    logic [2:0] status;
    logic       cutoff_fired;
    logic       solenoid_on;
    logic       box_locked;
    logic       tamper_flag;
    logic       too_hot;
    logic [3:0] unjam_left;
  } result_t;

  // Handshake between the input register and the engine.
  typedef struct packed {
    logic valid;
    logic advance;
  } stage_ctl_t;

endpackage

### rtl/slsc_in_stage.sv
// Input register of the controller, holding one accepted event.
`timescale 1ns / 1ps

module slsc_in_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [3:0]          s_axis_tuser,  // kind
  input  logic [39:0]         s_axis_tdata,  // now_ms, reed_sample, ignore_reed, zero pad
  input  logic                advance,
  output slsc_pkg::item_t     item,
  output logic                item_valid
);
  import slsc_pkg::*;

  // The register takes a new transaction when it is empty or its event moves on.
  assign s_axis_tready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_axis_tready) begin
      item_valid <= s_axis_tvalid;
    end
  end

  // Payload capture.
  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item.kind        <= s_axis_tuser;
      item.now_ms      <= s_axis_tdata[31:0];
      item.reed_sample <= s_axis_tdata[32];
      item.ignore_reed <= s_axis_tdata[33];
    end
  end

endmodule

### rtl/slsc_engine.sv
// Controller state, configuration registers, single-pass update and result register.
`timescale 1ns / 1ps

module slsc_engine (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [slsc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [slsc_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  slsc_pkg::item_t                    item,
  output slsc_pkg::stage_ctl_t               ctl,
  input  logic                               item_valid,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output slsc_pkg::result_t                  result
);
  import slsc_pkg::*;

  // Configuration registers.
  logic [15:0] debounce_ms;
  logic [19:0] open_confirm_ms;
  logic [19:0] trigger_holdoff_ms;
  logic [19:0] boot_grace_ms;
  logic [19:0] max_active_ms;
  logic [31:0] temp_limit;
  logic [23:0] heat_per_pulse;
  logic [15:0] cool_per_ms;

  // Controller state.
  logic        reed_last, reed_last_next;
  logic        reed_stable, reed_stable_next;
  logic [31:0] reed_change_time, reed_change_time_next;
  logic [31:0] open_since_time, open_since_time_next;
  logic        open_since_valid, open_since_valid_next;
  logic        tamper_latched, tamper_latched_next;
  logic        tamper_suppressed, tamper_suppressed_next;
  logic        prev_qualified, prev_qualified_next;
  logic [31:0] tamper_time, tamper_time_next;
  logic        tamper_time_valid, tamper_time_valid_next;
  logic [31:0] boot_time, boot_time_next;
  logic        drive_on, drive_on_next;
  logic [31:0] drive_on_time, drive_on_time_next;
  logic [31:0] coil_temp, coil_temp_next;
  logic [31:0] last_cool_time, last_cool_time_next;
  logic [3:0]  unjam_count, unjam_count_next;
  logic [31:0] unjam_time, unjam_time_next;
  logic        unjam_time_valid, unjam_time_valid_next;
  logic [31:0] unjam_off_time, unjam_off_time_next;
  logic        unjam_off_pending, unjam_off_pending_next;

  logic        fire;
  logic [2:0]  status;
  logic        cutoff;
  logic        qualified;
  logic [31:0] cool_elapsed;
  logic [47:0] cool_drop;
  logic [48:0] floor_sum;
  logic [32:0] heat_sum;
  logic [31:0] heated_temp;
  logic        hot_now;
  logic        unjam_idle;

  // The engine moves when the result register is free or being drained.
  assign ctl.valid   = item_valid;
  assign ctl.advance = !m_axis_tvalid || m_axis_tready;
  assign fire        = item_valid && ctl.advance;

  // Shared arithmetic: cooling drop, saturating heat and overheat test.
  assign cool_elapsed = item.now_ms - last_cool_time;
  assign cool_drop    = 48'(cool_elapsed) * 48'(cool_per_ms);
  assign floor_sum    = 49'(TEMP_FLOOR) + 49'(cool_drop);
  assign heat_sum     = {1'b0, coil_temp} + 33'(heat_per_pulse);
  assign heated_temp  = heat_sum[32] ? 32'hFFFF_FFFF : heat_sum[31:0];
  assign hot_now      = coil_temp >= temp_limit;
  assign unjam_idle   = (unjam_count != 4'd0) && unjam_time_valid &&
                        ((item.now_ms - unjam_time) >= UNJAM_IDLE_RESET_MS);

  // Next state for the event in the input register.
  always_comb begin
    logic        rl;
    logic [31:0] rct;
    logic        stable;
    logic        osv;
    logic [31:0] ost;
    logic        cooldown;
    logic        grace;
    logic        confirmed;
    logic        drv;
    logic        pend;
    logic [3:0]  cnt;
    logic        utv;

    rl        = reed_last;
    rct       = reed_change_time;
    stable    = reed_stable;
    osv       = open_since_valid;
    ost       = open_since_time;
    cooldown  = 1'b0;
    grace     = 1'b0;
    confirmed = 1'b0;
    drv       = drive_on;
    pend      = unjam_off_pending;
    cnt       = unjam_count;
    utv       = unjam_time_valid;

    reed_last_next         = reed_last;
    reed_stable_next       = reed_stable;
    reed_change_time_next  = reed_change_time;
    open_since_time_next   = open_since_time;
    open_since_valid_next  = open_since_valid;
    tamper_latched_next    = tamper_latched;
    tamper_suppressed_next = tamper_suppressed;
    prev_qualified_next    = prev_qualified;
    tamper_time_next       = tamper_time;
    tamper_time_valid_next = tamper_time_valid;
    boot_time_next         = boot_time;
    drive_on_next          = drive_on;
    drive_on_time_next     = drive_on_time;
    coil_temp_next         = coil_temp;
    last_cool_time_next    = last_cool_time;
    unjam_count_next       = unjam_count;
    unjam_time_next        = unjam_time;
    unjam_time_valid_next  = unjam_time_valid;
    unjam_off_time_next    = unjam_off_time;
    unjam_off_pending_next = unjam_off_pending;
    status                 = STATUS_OK;
    cutoff                 = 1'b0;
    qualified              = 1'b0;

    case (item.kind)
      KIND_TICK: begin
        // Reed debounce.
        if (item.reed_sample != rl) begin
          rl  = item.reed_sample;
          rct = item.now_ms;
        end
        if ((item.now_ms - rct) >= 32'(debounce_ms)) begin
          stable = rl;
        end
        // Sustained-open timing.
        if (!stable) begin
          if (!osv) begin
            osv = 1'b1;
            ost = item.now_ms;
          end
        end else begin
          osv = 1'b0;
        end
        // Tamper qualification on a rising edge outside cooldown and grace.
        cooldown  = tamper_time_valid &&
                    ((item.now_ms - tamper_time) < 32'(trigger_holdoff_ms));
        grace     = (item.now_ms - boot_time) < 32'(boot_grace_ms);
        confirmed = osv && ((item.now_ms - ost) >= 32'(open_confirm_ms));
        qualified = confirmed && !drive_on && !tamper_suppressed && !grace;
        if (!prev_qualified && qualified && !cooldown) begin
          tamper_latched_next    = 1'b1;
          tamper_time_next       = item.now_ms;
          tamper_time_valid_next = 1'b1;
        end
        prev_qualified_next   = qualified;
        reed_last_next        = rl;
        reed_change_time_next = rct;
        reed_stable_next      = stable;
        open_since_valid_next = osv;
        open_since_time_next  = ost;
        // Coil cooling, floored at 25 C.
        if (cool_elapsed != 32'd0) begin
          if (49'(coil_temp) < floor_sum) begin
            coil_temp_next = TEMP_FLOOR;
          end else begin
            coil_temp_next = coil_temp - cool_drop[31:0];
          end
        end
        last_cool_time_next = item.now_ms;
        // Unjam auto-off once the scheduled time is reached.
        if (pend && !((item.now_ms - unjam_off_time) >= 32'h8000_0000)) begin
          drv  = 1'b0;
          pend = 1'b0;
        end
        // Hard on-time cutoff.
        if (drv && ((item.now_ms - drive_on_time) >= 32'(max_active_ms))) begin
          drv    = 1'b0;
          pend   = 1'b0;
          cutoff = 1'b1;
        end
        drive_on_next          = drv;
        unjam_off_pending_next = pend;
      end
      KIND_INIT: begin
        reed_last_next         = item.reed_sample;
        reed_stable_next       = item.reed_sample;
        last_cool_time_next    = item.now_ms;
        tamper_time_valid_next = 1'b0;
        boot_time_next         = item.now_ms;
        open_since_valid_next  = !item.reed_sample;
        open_since_time_next   = item.now_ms;
        prev_qualified_next    = 1'b0;
        drive_on_next          = 1'b0;
      end
      KIND_UNLOCK: begin
        if (hot_now) begin
          status = STATUS_OVERHEATED;
        end else begin
          drive_on_next          = 1'b1;
          drive_on_time_next     = item.now_ms;
          coil_temp_next         = heated_temp;
          unjam_off_pending_next = 1'b0;
        end
      end
      KIND_LOCK: begin
        drive_on_next = 1'b0;
        if (!item.ignore_reed && !item.reed_sample) begin
          status = STATUS_STUCK_OPEN;
        end else begin
          reed_stable_next = 1'b1;
        end
      end
      KIND_UNJAM: begin
        // Idle counter reset comes before every guard.
        if (unjam_idle) begin
          cnt                    = 4'd0;
          utv                    = 1'b0;
          unjam_off_pending_next = 1'b0;
        end
        unjam_count_next      = cnt;
        unjam_time_valid_next = utv;
        if (hot_now) begin
          status = STATUS_OVERHEATED;
        end else if (utv && ((item.now_ms - unjam_time) < UNJAM_GAP_MS)) begin
          status = STATUS_UNJAM_COOL;
        end else if (cnt >= UNJAM_PULSES_MAX) begin
          status = STATUS_UNJAM_LIMIT;
        end else begin
          drive_on_next          = 1'b1;
          drive_on_time_next     = item.now_ms;
          coil_temp_next         = heated_temp;
          unjam_off_time_next    = item.now_ms + UNJAM_WIDTH_MS;
          unjam_off_pending_next = 1'b1;
          unjam_count_next       = cnt + 4'd1;
          unjam_time_next        = item.now_ms;
          unjam_time_valid_next  = 1'b1;
        end
      end
      KIND_CLR_TAMPER: tamper_latched_next    = 1'b0;
      KIND_SUPPRESS:   tamper_suppressed_next = 1'b1;
      KIND_ARM:        tamper_suppressed_next = 1'b0;
      KIND_RESET_UNJAM: begin
        unjam_count_next       = 4'd0;
        unjam_time_valid_next  = 1'b0;
        unjam_off_pending_next = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms        <= DEBOUNCE_RST;
      open_confirm_ms    <= OPEN_CONFIRM_RST;
      trigger_holdoff_ms <= COOLDOWN_RST;
      boot_grace_ms      <= BOOT_GRACE_RST;
      max_active_ms      <= MAX_ACTIVE_RST;
      temp_limit         <= TEMP_LIMIT_RST;
      heat_per_pulse     <= HEAT_PER_PULSE_RST;
      cool_per_ms        <= COOL_PER_MS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEBOUNCE:       debounce_ms        <= cfg_data[15:0];
        REG_OPEN_CONFIRM:   open_confirm_ms    <= cfg_data[19:0];
        REG_COOLDOWN:       trigger_holdoff_ms <= cfg_data[19:0];
        REG_BOOT_GRACE:     boot_grace_ms      <= cfg_data[19:0];
        REG_MAX_ACTIVE:     max_active_ms      <= cfg_data[19:0];
        REG_TEMP_LIMIT:     temp_limit         <= cfg_data[31:0];
        REG_HEAT_PER_PULSE: heat_per_pulse     <= cfg_data[23:0];
        REG_COOL_PER_MS:    cool_per_ms        <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // State update, one event per cycle while the result register is free or being drained.
  always_ff @(posedge clk) begin
    if (rst) begin
      reed_last         <= 1'b1;
      reed_stable       <= 1'b1;
      reed_change_time  <= 32'd0;
      open_since_time   <= 32'd0;
      open_since_valid  <= 1'b0;
      tamper_latched    <= 1'b0;
      tamper_suppressed <= 1'b0;
      prev_qualified    <= 1'b0;
      tamper_time       <= 32'd0;
      tamper_time_valid <= 1'b0;
      boot_time         <= 32'd0;
      drive_on          <= 1'b0;
      drive_on_time     <= 32'd0;
      coil_temp         <= TEMP_FLOOR;
      last_cool_time    <= 32'd0;
      unjam_count       <= 4'd0;
      unjam_time        <= 32'd0;
      unjam_time_valid  <= 1'b0;
      unjam_off_time    <= 32'd0;
      unjam_off_pending <= 1'b0;
    end else if (fire) begin
      reed_last         <= reed_last_next;
      reed_stable       <= reed_stable_next;
      reed_change_time  <= reed_change_time_next;
      open_since_time   <= open_since_time_next;
      open_since_valid  <= open_since_valid_next;
      tamper_latched    <= tamper_latched_next;
      tamper_suppressed <= tamper_suppressed_next;
      prev_qualified    <= prev_qualified_next;
      tamper_time       <= tamper_time_next;
      tamper_time_valid <= tamper_time_valid_next;
      boot_time         <= boot_time_next;
      drive_on          <= drive_on_next;
      drive_on_time     <= drive_on_time_next;
      coil_temp         <= coil_temp_next;
      last_cool_time    <= last_cool_time_next;
      unjam_count       <= unjam_count_next;
      unjam_time        <= unjam_time_next;
      unjam_time_valid  <= unjam_time_valid_next;
      unjam_off_time    <= unjam_off_time_next;
      unjam_off_pending <= unjam_off_pending_next;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (ctl.advance) begin
      m_axis_tvalid <= item_valid;
    end
  end

  // Result payload from the state after the event.
  always_ff @(posedge clk) begin
    if (fire) begin
      result.status       <= status;
      result.cutoff_fired <= cutoff;
      result.solenoid_on  <= drive_on_next;
      result.box_locked   <= reed_stable_next;
      result.tamper_flag  <= tamper_latched_next;
      result.too_hot      <= coil_temp_next >= temp_limit;
      result.unjam_left   <= (unjam_count_next < UNJAM_PULSES_MAX) ?
                             (UNJAM_PULSES_MAX - unjam_count_next) : 4'd0;
    end
  end

endmodule

### rtl/solenoid_lock_safety_controller_core.sv
// Top level of the solenoid lock safety controller.
// The block takes one event per clock cycle while the output is not stalled and returns
// one result for each, passing through the input register and then the result register.
// The rate is set by the state update, which reads and writes all controller state
// between those registers; the cooling step there uses one 32 by 16 multiplier.
// Configuration writes take effect at the next edge and no clearing pass follows reset.
`timescale 1ns / 1ps

module solenoid_lock_safety_controller_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [slsc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [slsc_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [3:0]                         s_axis_tuser,  // kind
  input  logic [39:0]                        s_axis_tdata,  // now_ms, reed_sample,
                                                            // ignore_reed, zero pad
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [15:0]                        m_axis_tdata   // status, cutoff_fired,
                                                            // solenoid_on, box_locked,
                                                            // tamper_flag, too_hot,
                                                            // unjam_left, zero pad
);
  import slsc_pkg::*;

  item_t      item;
  logic       item_valid;
  stage_ctl_t ctl;
  result_t    result;

  slsc_in_stage u_in_stage (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .advance       (ctl.advance),
    .item          (item),
    .item_valid    (item_valid)
  );

  slsc_engine u_engine (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .item          (item),
    .ctl           (ctl),
    .item_valid    (item_valid),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .result        (result)
  );

  // Result packing, first field in the lowest bits.
  assign m_axis_tdata = {4'd0, result.unjam_left, result.too_hot, result.tamper_flag,
                         result.box_locked, result.solenoid_on, result.cutoff_fired,
                         result.status};

endmodule

### rtl/slsc_checker.sv
// Port-level checks of the controller and their attachment to the top level.
`timescale 1ns / 1ps

module slsc_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);
  import slsc_pkg::*;

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // A stalled result keeps its data.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

  // The pulse budget never exceeds its maximum.
  a_unjam_left: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[11:8] <= UNJAM_PULSES_MAX))
    else $error("unjam budget out of range");

  // A cutoff comes only from a tick, which leaves the drive off and reports no status.
  a_cutoff_off: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[3]) |-> (!m_axis_tdata[4] && m_axis_tdata[2:0] == STATUS_OK))
    else $error("cutoff with drive on or status set");

  // A refusal for heat leaves the coil at or above its limit.
  a_overheat: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[2:0] == STATUS_OVERHEATED) |-> m_axis_tdata[7])
    else $error("overheat status without too_hot");

endmodule

bind solenoid_lock_safety_controller_core slsc_checker u_slsc_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
